>>> rtl/dhb_pkg.sv
// Shared types and constants for the dual H-bridge PWM block.
// Used by dhb_ctrl, dhb_dp and dual_hbridge_pwm_with_deadtime; no dependencies.
package dhb_pkg;

	localparam int PWM_BITS        = 8;
	localparam int SPEED_FRAC_BITS = 8;

	localparam logic [15:0] MAX_DUTY_RST  = 16'((((1 << PWM_BITS) - 1) * 15) / 16);
	localparam logic [6:0]  SPEED_MAX_RST = 7'd100;
	localparam logic        ALLOW_REV_RST = 1'b1;
	localparam logic [7:0]  DEADTIME_RST  = 8'd10;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_MAX_DUTY  = 2'd0;
	localparam logic [1:0] REG_SPEED_MAX = 2'd1;
	localparam logic [1:0] REG_ALLOW_REV = 2'd2;
	localparam logic [1:0] REG_DEADTIME  = 2'd3;

	localparam logic OP_DRIVE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Quotient of the speed divider is at most 100, so seven bits
	localparam int          QUO_BITS  = 7;
	localparam logic [2:0]  DIV_FIRST = 3'(QUO_BITS - 1);

	// floor(x / 100) = (x * RECIP) >> RECIP_SHIFT for x below 2^23
	localparam int          RECIP_SHIFT = 30;
	localparam logic [23:0] RECIP       = 24'(((1 << RECIP_SHIFT) + 99) / 100);

	typedef enum logic [1:0] {
		DIR_IDLE = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_REV  = 2'd2
	} dir_t;

	typedef struct packed {
		logic               opcode;
		logic signed [15:0] left_speed;
		logic signed [15:0] right_speed;
	} cmd_t;

	typedef struct packed {
		logic [15:0] left_fwd_duty;
		logic [15:0] left_rev_duty;
		logic [15:0] right_fwd_duty;
		logic [15:0] right_rev_duty;
		logic        left_in_deadtime;
		logic        right_in_deadtime;
	} res_t;

	// Controller to datapath
	typedef struct packed {
		logic       load;
		logic       dinit;
		logic       dstep;
		logic [2:0] shift;
		logic       mul1;
		logic       mul2;
		logic       apply;
		logic       tick;
		logic       emit;
		logic       sel;
	} ctrl_cmd_t;

endpackage

>>> rtl/dual_hbridge_pwm_with_deadtime.sv
// Dual H-bridge PWM drive with reversal deadtime, top level.
// Instantiates dhb_ctrl and dhb_dp; types and constants from dhb_pkg.
//
// Input channel cmd (cmd_valid / cmd_stall) carries a drive transaction (two
// signed Q8.8 speeds) or a tick. Every transaction yields exactly one result on
// res (res_valid / res_stall): the four leg duties and two deadtime flags as
// they stand after that transaction.
// res_valid rises after a drive is accepted, once each bridge in turn has
// taken a load step, a restoring divide by speed_max with a seven-bit
// quotient, two multiply steps (percent times max_duty, then the reciprocal of
// 100) and a state update step; an emit step then writes the output register.
// The divider and multipliers are shared by both bridges. A tick passes a
// tick step and then the emit step.
// One transaction is worked at a time; the next is accepted as soon as the
// result sits in the output register, even if it has not been taken yet.
// If res_stall holds the previous result, the finished result waits in the
// sequencer and cmd stays stalled until the output register frees.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered; the user
// makes them while no transaction is in flight, as the block does not enforce it.
// Reset restores the register defaults, makes both bridges idle with no
// deadtime pending and empties the output register.
module dual_hbridge_pwm_with_deadtime import dhb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  cmd_t        cmd,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res
);

	ctrl_cmd_t ctl;

	dhb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_opcode (cmd.opcode),
		.cmd_stall  (cmd_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.ctl        (ctl)
	);

	dhb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.ctl       (ctl),
		.res       (res)
	);

endmodule

>>> rtl/dhb_ctrl.sv
// Sequencer for the dual H-bridge block: accepts a transaction, steps the
// datapath through divide, multiply and state update per bridge. Uses dhb_pkg.
module dhb_ctrl import dhb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  logic      cmd_opcode,
	output logic      cmd_stall,
	output logic      res_valid,
	input  logic      res_stall,
	output ctrl_cmd_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DINIT,
		S_DIV,
		S_MUL1,
		S_MUL2,
		S_APPLY,
		S_TICK,
		S_EMIT
	} state_t;

	state_t     state_q;
	logic [2:0] cnt_q;
	logic       sel_q;
	logic       out_valid_q;
	logic       accept;
	logic       emit;

	assign accept    = (state_q == S_IDLE) && cmd_valid;
	assign emit      = (state_q == S_EMIT) && (!out_valid_q || !res_stall);
	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = out_valid_q;

	always_comb begin
		ctl       = '0;
		ctl.load  = accept;
		ctl.dinit = (state_q == S_DINIT);
		ctl.dstep = (state_q == S_DIV);
		ctl.shift = cnt_q;
		ctl.mul1  = (state_q == S_MUL1);
		ctl.mul2  = (state_q == S_MUL2);
		ctl.apply = (state_q == S_APPLY);
		ctl.tick  = (state_q == S_TICK);
		ctl.emit  = emit;
		ctl.sel   = sel_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			sel_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (res_valid && !res_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						sel_q   <= 1'b0;
						state_q <= (cmd_opcode == OP_TICK) ? S_TICK : S_DINIT;
					end
				end
				S_DINIT: begin
					cnt_q   <= DIV_FIRST;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == '0)
						state_q <= S_MUL1;
					else
						cnt_q <= cnt_q - 3'd1;
				end
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_APPLY;
				S_APPLY: begin
					// advance to the right bridge, then publish
					if (!sel_q) begin
						sel_q   <= 1'b1;
						state_q <= S_DINIT;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_TICK:  state_q <= S_EMIT;
				S_EMIT: begin
					if (emit)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("controller idle right after accepting a transaction");

	a_emit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_valid_q && res_stall) |=> (state_q == S_EMIT))
		else $error("result published over an untaken one");

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("result valid not raised after emit");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q <= DIV_FIRST))
		else $error("divider step count out of range");

endmodule

>>> rtl/dhb_dp.sv
// Datapath for the dual H-bridge block: configuration registers, bridge state,
// shared speed divider, duty multiplier and result register. Uses dhb_pkg.
module dhb_dp import dhb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  cmd_t        cmd,
	input  ctrl_cmd_t   ctl,
	output res_t        res
);

	logic [15:0] max_duty_q;
	logic [6:0]  speed_max_q;
	logic        allow_rev_q;
	logic [7:0]  deadtime_q;

	logic signed [15:0] spd_q [2];
	dir_t               dir_q [2];
	logic [15:0]        pend_q [2];
	logic [7:0]         dead_q [2];

	logic [13:0]         rem_q;
	logic [QUO_BITS-1:0] quo_q;
	logic [22:0]         prod1_q;
	logic [46:0]         prod2_q;
	res_t                res_q;

	logic [15:0]        mag;
	logic               below_half;
	dir_t               ndir;
	logic [13:0]        dividend;
	logic [13:0]        trial;
	logic [15:0]        duty;

	// Clamp, reverse gate and magnitude for the selected bridge
	always_comb begin
		logic signed [16:0] s;
		logic signed [16:0] lim;
		logic [21:0]        mag100;
		s   = 17'(spd_q[ctl.sel]);
		lim = signed'(17'(speed_max_q) << SPEED_FRAC_BITS);
		if (s > lim)
			s = lim;
		if (s < -lim)
			s = -lim;
		if (!allow_rev_q && s < 0)
			s = '0;
		mag        = (s < 0) ? 16'(-s) : 16'(s);
		below_half = (mag < 16'(1 << (SPEED_FRAC_BITS - 1)));
		ndir       = (s > 0) ? DIR_FWD : DIR_REV;
		mag100     = 22'(mag) * 22'd100;
		dividend   = 14'(mag100 >> SPEED_FRAC_BITS);
	end

	assign trial = 14'(speed_max_q) << ctl.shift;
	assign duty  = prod2_q[RECIP_SHIFT +: 16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_duty_q  <= MAX_DUTY_RST;
			speed_max_q <= SPEED_MAX_RST;
			allow_rev_q <= ALLOW_REV_RST;
			deadtime_q  <= DEADTIME_RST;
			for (int b = 0; b < 2; b++) begin
				dir_q[b]  <= DIR_IDLE;
				pend_q[b] <= '0;
				dead_q[b] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_DUTY:  max_duty_q  <= cfg_data;
					REG_SPEED_MAX: speed_max_q <= cfg_data[6:0];
					REG_ALLOW_REV: allow_rev_q <= cfg_data[0];
					REG_DEADTIME:  deadtime_q  <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (ctl.tick) begin
				for (int b = 0; b < 2; b++) begin
					if (dead_q[b] != '0)
						dead_q[b] <= dead_q[b] - 8'd1;
				end
			end
			if (ctl.apply) begin
				if (below_half) begin
					dir_q[ctl.sel]  <= DIR_IDLE;
					pend_q[ctl.sel] <= '0;
					dead_q[ctl.sel] <= '0;
				end else begin
					dir_q[ctl.sel]  <= ndir;
					pend_q[ctl.sel] <= duty;
					// a flip away from a driven direction restarts the deadtime
					if (ndir != dir_q[ctl.sel] && dir_q[ctl.sel] != DIR_IDLE)
						dead_q[ctl.sel] <= deadtime_q;
				end
			end
		end
	end

	// Restoring divide of the scaled magnitude by speed_max, one bit a cycle
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			spd_q[0] <= cmd.left_speed;
			spd_q[1] <= cmd.right_speed;
		end
		if (ctl.dinit) begin
			rem_q <= dividend;
			quo_q <= '0;
		end else if (ctl.dstep) begin
			if (rem_q >= trial) begin
				rem_q            <= rem_q - trial;
				quo_q[ctl.shift] <= 1'b1;
			end
		end
		if (ctl.mul1)
			prod1_q <= 23'(quo_q) * 23'(max_duty_q);
		if (ctl.mul2)
			prod2_q <= 47'(prod1_q) * 47'(RECIP);
		if (ctl.emit) begin
			res_q.left_fwd_duty     <= (dir_q[0] == DIR_FWD && dead_q[0] == '0) ? pend_q[0] : '0;
			res_q.left_rev_duty     <= (dir_q[0] == DIR_REV && dead_q[0] == '0) ? pend_q[0] : '0;
			res_q.right_fwd_duty    <= (dir_q[1] == DIR_FWD && dead_q[1] == '0) ? pend_q[1] : '0;
			res_q.right_rev_duty    <= (dir_q[1] == DIR_REV && dead_q[1] == '0) ? pend_q[1] : '0;
			res_q.left_in_deadtime  <= (dead_q[0] != '0);
			res_q.right_in_deadtime <= (dead_q[1] != '0);
		end
	end

	assign res = res_q;

endmodule
